// File: hdl/svv_pkg.sv
// Shared types, status codes and character classes for the version string validator.
`timescale 1ns / 1ps
`default_nettype none
package svv_pkg;

  // Result status codes.
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Separator characters and the leading-zero character.
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Which part of the version string is open.
  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_PRE  = 2'd1,
    PH_META = 2'd2
  } phase_t;

  // One input item as it travels between the input stage and the parser.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) || (c == CH_MINUS);
  endfunction

endpackage
`default_nettype wire

// File: hdl/svv_in_stage.sv
// Input register stage that holds one item until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module svv_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire svv_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               stage_valid,
  output svv_pkg::item_t     stage_item
);
  import svv_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // The stage frees up in the same cycle that its item moves on.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule
`default_nettype wire

// File: hdl/svv_parser.sv
// Parser state and the per-character update logic for one version string.
`timescale 1ns / 1ps
`default_nettype none
module svv_parser #(
  parameter int MAX_LEN         = 64,
  parameter int MAX_IDENTS      = 8,
  parameter int MAX_BASE_IDENTS = 3
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire svv_pkg::item_t item,
  output logic [1:0]          status
);
  import svv_pkg::*;

  // Identifier count saturates one above the limit; character count at the limit.
  localparam int CW = $clog2(MAX_IDENTS + 2);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MAXI = CW'(MAX_IDENTS);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BASE_IDENTS);
  localparam logic [LW-1:0] MAXL = LW'(MAX_LEN);

  typedef struct packed {
    phase_t        phase;
    logic [1:0]    ilen;
    logic          all_digits;
    logic          first_zero;
    logic [CW-1:0] icnt;
    logic [1:0]    err_base;
    logic [1:0]    err_pre;
    logic [1:0]    err_meta;
    logic [LW-1:0] ccnt;
    logic          too_long;
  } pstate_t;

  localparam pstate_t PS_RESET = '{
    phase: PH_BASE, ilen: 2'd0, all_digits: 1'b1, first_zero: 1'b0,
    icnt: '0, err_base: ST_VALID, err_pre: ST_VALID, err_meta: ST_VALID,
    ccnt: '0, too_long: 1'b0
  };

  pstate_t st_r, st_nxt;
  pstate_t st_char;
  pstate_t st_end;

  // Keep the strongest error seen in the open part.
  function automatic pstate_t raise_err(input pstate_t s, input logic [1:0] code);
    pstate_t r;
    r = s;
    unique case (s.phase)
      PH_BASE: if (r.err_base < code) r.err_base = code;
      PH_PRE:  if (r.err_pre < code) r.err_pre = code;
      default: if (r.err_meta < code) r.err_meta = code;
    endcase
    return r;
  endfunction

  function automatic pstate_t open_ident(input pstate_t s);
    pstate_t r;
    r = s;
    r.ilen       = 2'd0;
    r.all_digits = 1'b1;
    r.first_zero = 1'b0;
    return r;
  endfunction

  function automatic pstate_t close_ident(input pstate_t s);
    pstate_t r;
    logic    bad;
    r   = s;
    bad = 1'b0;
    if (s.ilen == 2'd0) begin
      bad = 1'b1;
    end else if (s.phase == PH_BASE) begin
      bad = !s.all_digits || (s.first_zero && (s.ilen >= 2'd2));
    end else if (s.phase == PH_PRE) begin
      bad = s.all_digits && s.first_zero && (s.ilen >= 2'd2);
    end
    if (bad) r = raise_err(r, ST_INVALID);
    if (r.icnt <= MAXI) r.icnt = r.icnt + 1'b1;
    if (r.icnt > MAXI) r = raise_err(r, ST_TOO_MANY);
    return open_ident(r);
  endfunction

  // An empty prerelease or metadata part is accepted.
  function automatic pstate_t close_part(input pstate_t s);
    pstate_t r;
    logic    empty;
    r     = s;
    empty = (s.phase != PH_BASE) && (s.icnt == '0) && (s.ilen == 2'd0);
    if (!empty) begin
      r = close_ident(r);
      if ((r.phase == PH_BASE) && (r.icnt > MAXB)) r = raise_err(r, ST_INVALID);
    end
    r.icnt = '0;
    return open_ident(r);
  endfunction

  function automatic pstate_t take_char(input pstate_t s, input logic [7:0] c);
    pstate_t r;
    logic    digit;
    logic    ok;
    r     = s;
    digit = is_digit(c);
    ok    = (s.phase == PH_BASE) ? digit : is_ident_char(c);
    if (s.ccnt >= MAXL) begin
      r.too_long = 1'b1;
    end else begin
      r.ccnt = s.ccnt + 1'b1;
    end
    if (c == CH_DOT) begin
      r = close_ident(r);
    end else if ((c == CH_MINUS) && (s.phase == PH_BASE)) begin
      r       = close_part(r);
      r.phase = PH_PRE;
    end else if ((c == CH_PLUS) && (s.phase != PH_META)) begin
      r       = close_part(r);
      r.phase = PH_META;
    end else begin
      // A second plus inside the metadata part falls through here as a bad byte.
      if (!ok) r = raise_err(r, ST_INVALID);
      if (s.ilen == 2'd0) r.first_zero = (c == CH_ZERO);
      if (!digit) r.all_digits = 1'b0;
      if (s.ilen < 2'd2) r.ilen = s.ilen + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    st_char = item.has_char ? take_char(st_r, item.ch) : st_r;
    st_end  = close_part(st_char);
    priority if (st_end.too_long) begin
      status = ST_TOO_LONG;
    end else if (st_end.err_base != ST_VALID) begin
      status = st_end.err_base;
    end else if (st_end.err_pre != ST_VALID) begin
      status = st_end.err_pre;
    end else begin
      status = st_end.err_meta;
    end
    st_nxt = st_r;
    if (step) begin
      st_nxt = item.last ? PS_RESET : st_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PS_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/svv_out_stage.sv
// Result register that holds one status item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module svv_out_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire logic [1:0] status,
  output logic            free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status
);
  import svv_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] status_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

// File: hdl/semver_string_validator.sv
// Top level of the semantic version string validator.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// The input channel carries a version string, one character per item. in_tdata
// holds the character byte, in_tuser says whether that byte is a character (an
// item with in_tuser low only ends the string when in_tlast is high, and is
// ignored otherwise), and in_tlast marks the final item of the string.
// Each string gives exactly one result item on the output channel, produced
// for its last item: 0 valid, 1 invalid, 2 too many identifiers, 3 too long.
// When the result register is free, the last item passes through the input
// register and its result is loaded from there into the result register,
// which raises out_tvalid. Throughput is one item per cycle while no last item
// waits for the result register, set by the combinational character update
// between the input register and the parser state.
// When the receiver stalls, the result register holds its item and the block
// keeps taking characters; only a second last item waits in the input
// register until the result register frees up, and in_tready drops then.
// Synchronous reset (rst_n low) empties both registers and returns the parser
// to the start of a string.
module semver_string_validator #(
  parameter int MAX_LEN         = 64,
  parameter int MAX_IDENTS      = 8,
  parameter int MAX_BASE_IDENTS = 3
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic       in_tuser,   // [0] has_char
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [1:0] status, [7:2] zero
);
  import svv_pkg::*;

  item_t      in_item;
  item_t      stage_item;
  logic       stage_valid;
  logic       advance;
  logic       out_free;
  logic [1:0] status;
  logic [1:0] out_status;

  assign in_item = '{ch: in_tdata, has_char: in_tuser, last: in_tlast};

  // A character item always moves on; a last item needs room for its result.
  assign advance = stage_valid && (!stage_item.last || out_free);

  svv_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  svv_parser #(
    .MAX_LEN         (MAX_LEN),
    .MAX_IDENTS      (MAX_IDENTS),
    .MAX_BASE_IDENTS (MAX_BASE_IDENTS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_item),
    .status (status)
  );

  svv_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && stage_item.last),
    .status     (status),
    .free       (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status)
  );

  assign out_tdata = {6'd0, out_status};

endmodule
`default_nettype wire

// File: hdl/svv_checker.sv
// Port-level checks for the version string validator and their bind.
`timescale 1ns / 1ps
`default_nettype none
module svv_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input backpressure only ever comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("result padding not zero");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind semver_string_validator svv_checker u_svv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: test/tb_semver_string_validator.sv
// Self-checking testbench for the semantic version string validator.
`timescale 1ns / 1ps
`default_nettype none
module tb_semver_string_validator;
  import svv_pkg::*;

  localparam int LEN_LIMIT        = 64;
  localparam int IDENT_LIMIT      = 8;
  localparam int BASE_IDENT_LIMIT = 3;
  localparam int ITEM_TARGET      = 1050;
  localparam int CYCLE_LIMIT      = 400000;

  // How the receiver paces out_tready during one stretch of the run.
  typedef enum logic [1:0] {
    READY_ALWAYS   = 2'd0,
    READY_COIN     = 2'd1,
    READY_RARE     = 2'd2,
    READY_PERIODIC = 2'd3
  } ready_style_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] ch
  logic       in_tuser   = 1'b0;   // [0] has_char
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [1:0] status, [7:2] zero

  semver_string_validator #(
    .MAX_LEN        (LEN_LIMIT),
    .MAX_IDENTS     (IDENT_LIMIT),
    .MAX_BASE_IDENTS(BASE_IDENT_LIMIT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and expectations.
  item_t      pending_items[$];
  logic [1:0] expected_status[$];
  logic [7:0] version_text[$];
  int         counted_items = 0;
  int         error_count   = 0;
  int         cycle_count   = 0;
  string      ident_alphabet =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-";

  // Predicted parser state.
  phase_t     cur_phase;
  logic [1:0] open_len;
  logic       open_digits_only;
  logic       open_lead_zero;
  logic [3:0] idents_in_part;
  logic [1:0] part_status[3];
  logic [7:0] chars_seen;
  logic       over_length;

  function automatic void flag_part(logic [1:0] code);
    if (part_status[cur_phase] < code) part_status[cur_phase] = code;
  endfunction

  function automatic void start_ident();
    open_len         = 2'd0;
    open_digits_only = 1'b1;
    open_lead_zero   = 1'b0;
  endfunction

  function automatic void restart_parser();
    cur_phase = PH_BASE;
    start_ident();
    idents_in_part = 4'd0;
    for (int p = 0; p < 3; p++) part_status[p] = ST_VALID;
    chars_seen  = 8'd0;
    over_length = 1'b0;
  endfunction

  function automatic void finish_ident();
    logic bad;
    bad = 1'b0;
    if (open_len == 2'd0)
      bad = 1'b1;
    else if (cur_phase == PH_BASE)
      bad = !open_digits_only || (open_lead_zero && open_len >= 2'd2);
    else if (cur_phase == PH_PRE)
      bad = open_digits_only && open_lead_zero && open_len >= 2'd2;
    if (bad) flag_part(ST_INVALID);
    if (idents_in_part <= IDENT_LIMIT) idents_in_part++;
    if (idents_in_part > IDENT_LIMIT) flag_part(ST_TOO_MANY);
    start_ident();
  endfunction

  // A prerelease or metadata part that never got a character is accepted as empty.
  function automatic void finish_part();
    logic empty_part;
    empty_part = (cur_phase != PH_BASE) && (idents_in_part == 4'd0) && (open_len == 2'd0);
    if (!empty_part) begin
      finish_ident();
      if (cur_phase == PH_BASE && idents_in_part > BASE_IDENT_LIMIT) flag_part(ST_INVALID);
    end
    idents_in_part = 4'd0;
    start_ident();
  endfunction

  function automatic void take_byte(logic [7:0] c);
    logic is_num;
    logic is_word_char;
    if (chars_seen >= LEN_LIMIT) over_length = 1'b1;
    else chars_seen++;
    is_num = (c >= 8'h30) && (c <= 8'h39);
    is_word_char = is_num || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c == CH_MINUS);
    if (c == CH_DOT) begin
      finish_ident();
    end else if (c == CH_MINUS && cur_phase == PH_BASE) begin
      finish_part();
      cur_phase = PH_PRE;
    end else if (c == CH_PLUS && cur_phase != PH_META) begin
      finish_part();
      cur_phase = PH_META;
    end else begin
      // A '+' inside the metadata part lands here and fails the character check.
      if (cur_phase == PH_BASE ? !is_num : !is_word_char) flag_part(ST_INVALID);
      if (open_len == 2'd0) open_lead_zero = (c == CH_ZERO);
      if (!is_num) open_digits_only = 1'b0;
      if (open_len < 2'd2) open_len++;
    end
  endfunction

  function automatic void predict_item(item_t it);
    logic [1:0] st;
    if (it.has_char) take_byte(it.ch);
    if (it.last) begin
      finish_part();
      if (over_length) st = ST_TOO_LONG;
      else if (part_status[0] != ST_VALID) st = part_status[0];
      else if (part_status[1] != ST_VALID) st = part_status[1];
      else st = part_status[2];
      expected_status.push_back(st);
      restart_parser();
    end
  endfunction

  // Turns the text under construction into items. Now and then an item without
  // a character and without last is slipped in; the block must ignore it.
  task automatic queue_text(bit end_marker);
    item_t it;
    for (int k = 0; k < version_text.size(); k++) begin
      if ($urandom_range(0, 19) == 0) begin
        it.ch       = 8'($urandom_range(0, 255));
        it.has_char = 1'b0;
        it.last     = 1'b0;
        pending_items.push_back(it);
      end
      it.ch       = version_text[k];
      it.has_char = 1'b1;
      it.last     = !end_marker && (k == version_text.size() - 1);
      pending_items.push_back(it);
      counted_items++;
    end
    if (end_marker || version_text.size() == 0) begin
      it.ch       = 8'($urandom_range(0, 255));
      it.has_char = 1'b0;
      it.last     = 1'b1;
      pending_items.push_back(it);
      counted_items++;
    end
  endtask

  task automatic queue_literal(string t);
    version_text.delete();
    for (int k = 0; k < t.len(); k++) version_text.push_back(t[k]);
    queue_text($urandom_range(0, 3) == 0);
  endtask

  task automatic add_number();
    int len;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : $urandom_range(1, 3);
    for (int k = 0; k < len; k++) begin
      if (k == 0 && len > 1 && $urandom_range(0, 7) == 0)
        version_text.push_back(CH_ZERO);
      else if (k == 0 && len > 1)
        version_text.push_back(8'($urandom_range(8'h31, 8'h39)));
      else
        version_text.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
  endtask

  task automatic add_word();
    int len;
    len = $urandom_range(1, 5);
    for (int k = 0; k < len; k++)
      version_text.push_back(ident_alphabet[$urandom_range(0, ident_alphabet.len() - 1)]);
  endtask

  task automatic add_ident_list(int n, bit numeric_only);
    for (int k = 0; k < n; k++) begin
      if (k != 0) version_text.push_back(CH_DOT);
      if (numeric_only || $urandom_range(0, 1) == 0) add_number();
      else add_word();
    end
  endtask

  // Mostly well-formed versions with random content; some get damaged, a few
  // are padded to around or past the length limit and some are plain byte noise.
  task automatic build_random_version();
    int n;
    int pos;
    int target_len;
    version_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, 8);
      for (int k = 0; k < n; k++) version_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 3);
    add_ident_list(n, 1'b1);
    if ($urandom_range(0, 1) == 0) begin
      version_text.push_back(CH_MINUS);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 3);
      add_ident_list(n, 1'b0);
    end
    if ($urandom_range(0, 2) == 0) begin
      version_text.push_back(CH_PLUS);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 3);
      add_ident_list(n, 1'b0);
    end
    if ($urandom_range(0, 3) == 0 && version_text.size() > 0) begin
      pos = $urandom_range(0, version_text.size() - 1);
      case ($urandom_range(0, 3))
        0: version_text[pos] = 8'($urandom_range(0, 255));
        1: version_text.insert(pos, CH_DOT);
        2: version_text.delete(pos);
        default: version_text.insert(pos, ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
      endcase
    end
    if ($urandom_range(0, 11) == 0) begin
      target_len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(LEN_LIMIT - 3, LEN_LIMIT + 3);
      while (version_text.size() < target_len)
        version_text.push_back(ident_alphabet[$urandom_range(0, ident_alphabet.len() - 1)]);
    end
  endtask

  // Sender: bursts of random length with random gaps, some bursts back to back.
  item_t cur_item;
  int    burst_left = 0;
  int    gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tdata  <= cur_item.ch;
          in_tuser  <= cur_item.has_char;
          in_tlast  <= cur_item.last;
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: out_tready follows one pacing style per stretch of cycles.
  ready_style_t ready_style = READY_ALWAYS;
  int           style_left  = 0;
  int           style_tick  = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(32, 400);
    end else begin
      style_left--;
    end
    style_tick++;
    case (ready_style)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      READY_RARE:   out_tready <= ($urandom_range(0, 7) == 0);
      default:      out_tready <= ((style_tick % 16) < 5);
    endcase
  end

  // Result checker: every result item is matched against the oldest expectation.
  logic [1:0] want_status;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $error("unexpected result item: status %0d", out_tdata[1:0]);
        error_count++;
      end else begin
        want_status = expected_status.pop_front();
        if (out_tdata[1:0] != want_status) begin
          $error("status: expected %0d, actual %0d", want_status, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[7:2] != 6'd0) begin
          $error("padding: expected 0, actual %0d", out_tdata[7:2]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    restart_parser();

    // Directed strings: the status codes, the precedence rules, the empty
    // prerelease part, the stray plus in metadata and foreign bytes.
    queue_literal("1.2.3");
    queue_literal("01");
    queue_literal("1.2.3.4");
    queue_literal("1-");
    queue_literal("1-01+");
    queue_literal("1+a+");
    queue_literal("");
    queue_literal("1..");
    queue_literal("a");
    queue_literal("1.2.3.4.5.6.7.8.9");
    queue_literal("1-0a.b.c.d.e.f.g.h.i");
    version_text.delete();
    version_text.push_back(8'h00);
    version_text.push_back(8'hff);
    queue_text(1'b0);
    version_text.delete();
    for (int k = 0; k <= LEN_LIMIT; k++) version_text.push_back(8'h31);
    queue_text(1'b0);

    while (counted_items < ITEM_TARGET) begin
      build_random_version();
      queue_text($urandom_range(0, 4) == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
